>>> sv/float32_remainder_quotient_macros.svh
// Assertion macros shared by the float32 remainder and quotient block.
`ifndef FLOAT32_REMAINDER_QUOTIENT_MACROS_SVH
`define FLOAT32_REMAINDER_QUOTIENT_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define FRQ_ASSERT_IMPL(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (b)) \
        else $error("frq same-cycle check failed");

// Next-cycle implication, checked on aclk outside reset.
`define FRQ_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (b)) \
        else $error("frq next-cycle check failed");

`endif

>>> sv/frq_pkg.sv
// Shared types and constants of the float32 remainder and quotient block.
`default_nettype none
package frq_pkg;
    typedef logic signed [11:0] exp_t;

    localparam logic [31:0] CANON_NAN     = 32'h7fc0_0000;
    localparam logic [31:0] INF_PATTERN   = 32'h7f80_0000;
    localparam logic [31:0] HIDDEN_BIT    = 32'h0080_0000;
    localparam exp_t        ZERO_EXP_MARK = -12'sd512;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_NORM_X,
        OP_NORM_Y,
        OP_DIV_STEP,
        OP_LAST_SUB,
        OP_RENORM,
        OP_PACK,
        OP_ADJ_SETUP,
        OP_ADJ_STEP,
        OP_OUT_NAN,
        OP_OUT_X,
        OP_OUT_CALC
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic invalid;
        logic x_zero;
        logic mx_top;
        logic my_top;
        logic x_far;
        logic x_below;
        logic div_more;
        logic mx_zero;
        logic need_adj;
        logic adj_more;
    } dp_status_t;
endpackage
`default_nettype wire

>>> sv/float32_remainder_quotient.sv
// Top level of the float32 IEEE remainder and quotient block.
// One beat at a time: a beat is loaded and checked, a subnormal operand is normalized by
// shifting, the shift-subtract loop takes one step per unit of exponent difference (up to 276),
// the remainder is renormalized by shifting and packed and, when needed, the final half-way
// correction shifts it. The shift-subtract loop takes the most time.
// A finished result sits in the output register, so the next beat can be taken while it waits.
`default_nettype none
module float32_remainder_quotient
    import frq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,  // dividend_bits [31:0], divisor_bits [63:32]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [63:0] m_tdata   // remainder_bits [31:0], quotient_low [63:32]
);
    dp_cmd_t     cmd;
    dp_status_t  status;
    logic [31:0] remainder_bits, quotient_low;

    frq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    frq_datapath u_datapath (
        .aclk           (aclk),
        .dividend_bits  (s_tdata[31:0]),
        .divisor_bits   (s_tdata[63:32]),
        .cmd            (cmd),
        .status         (status),
        .remainder_bits (remainder_bits),
        .quotient_low   (quotient_low)
    );

    assign m_tdata = {quotient_low, remainder_bits};
endmodule
`default_nettype wire

>>> sv/frq_datapath.sv
// Datapath of the float32 remainder and quotient block: significands, exponents and result.
`default_nettype none
module frq_datapath
    import frq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic [31:0] dividend_bits,
    input  wire logic [31:0] divisor_bits,
    input  wire dp_cmd_t     cmd,
    output dp_status_t       status,
    output logic      [31:0] remainder_bits,
    output logic      [31:0] quotient_low
);
    logic [31:0] xb_reg, yb_reg, rb_reg, rem_reg, quo_reg;
    logic [24:0] mx_reg;
    logic [23:0] my_reg, d_reg;
    exp_t        ex_reg, ey_reg;
    logic [30:0] q_reg;
    logic [7:0]  es_reg;
    logic        adj_reg;

    logic [31:0] yabs, twox, pack_rb, adj_rb, final_rb;
    logic [23:0] shifted, ss, sb, d_new;
    logic [24:0] mx_diff;
    logic        sub_ok;
    exp_t        ex_p1, sh;
    logic [7:0]  eb_raw, es_raw, eb_f, es_f, rbe, esm1;
    logic signed [9:0] dd;
    logic [2:0]  dsh;
    logic [30:0] big, diff, sum31, qf;
    logic [7:0]  load_ex, load_ey;

    always_comb begin
        yabs    = {1'b0, yb_reg[30:0]};
        ex_p1   = ex_reg + 12'sd1;
        sub_ok  = mx_reg >= {1'b0, my_reg};
        mx_diff = mx_reg - {1'b0, my_reg};
        sh      = 12'sd1 - ex_reg;
        shifted = (sh >= 12'sd24) ? 24'd0 : (mx_reg[23:0] >> sh[4:0]);
        pack_rb = (ex_reg > 12'sd0) ? {1'b0, ex_reg[7:0], mx_reg[22:0]} : {8'd0, shifted};

        rbe = rb_reg[30:23];
        if (rbe == 8'd0) begin
            twox = {rb_reg[30:0], 1'b0};
        end else if (rbe >= 8'd254) begin
            twox = INF_PATTERN;
        end else begin
            twox = rb_reg + HIDDEN_BIT;
        end

        eb_raw = yb_reg[30:23];
        es_raw = rb_reg[30:23];
        sb     = {eb_raw != 8'd0, yb_reg[22:0]};
        ss     = {es_raw != 8'd0, rb_reg[22:0]};
        eb_f   = (eb_raw == 8'd0) ? 8'd1 : eb_raw;
        es_f   = (es_raw == 8'd0) ? 8'd1 : es_raw;
        dd     = $signed({2'b00, eb_f}) - $signed({2'b00, es_f});
        if (dd < 10'sd0) begin
            dsh = 3'd0;
        end else if (dd > 10'sd7) begin
            dsh = 3'd7;
        end else begin
            dsh = dd[2:0];
        end
        big   = {7'd0, sb} << dsh;
        diff  = big - {7'd0, ss};
        d_new = diff[23:0];

        esm1     = es_reg - 8'd1;
        sum31    = {esm1, 23'd0} + {7'd0, d_reg};
        adj_rb   = {1'b1, (d_reg == 24'd0) ? 31'd0 : sum31};
        final_rb = adj_reg ? adj_rb : rb_reg;
        qf       = adj_reg ? (q_reg + 31'd1) : q_reg;

        load_ex = dividend_bits[30:23];
        load_ey = divisor_bits[30:23];

        status.invalid  = (yb_reg[30:0] == 31'd0) || (yabs > INF_PATTERN)
                          || (xb_reg[30:23] == 8'hff);
        status.x_zero   = xb_reg[30:0] == 31'd0;
        status.mx_top   = mx_reg[23];
        status.my_top   = my_reg[23];
        status.x_below  = ex_reg < ey_reg;
        status.x_far    = (ex_reg < ey_reg) && (ex_p1 != ey_reg);
        status.div_more = ex_reg > ey_reg;
        status.mx_zero  = mx_reg == 25'd0;
        status.need_adj = (ex_reg == ey_reg) || ((ex_p1 == ey_reg)
                          && ((twox > yabs) || ((twox == yabs) && q_reg[0])));
        status.adj_more = (d_reg != 24'd0) && !d_reg[23] && (es_reg > 8'd1);
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                xb_reg  <= dividend_bits;
                yb_reg  <= divisor_bits;
                ex_reg  <= $signed({4'd0, load_ex});
                ey_reg  <= $signed({4'd0, load_ey});
                mx_reg  <= (load_ex == 8'd0) ? {1'b0, dividend_bits[22:0], 1'b0}
                                             : {2'b01, dividend_bits[22:0]};
                my_reg  <= (load_ey == 8'd0) ? {divisor_bits[22:0], 1'b0}
                                             : {1'b1, divisor_bits[22:0]};
                q_reg   <= 31'd0;
                adj_reg <= 1'b0;
            end
            OP_NORM_X, OP_RENORM: begin
                mx_reg <= {mx_reg[23:0], 1'b0};
                ex_reg <= ex_reg - 12'sd1;
            end
            OP_NORM_Y: begin
                my_reg <= {my_reg[22:0], 1'b0};
                ey_reg <= ey_reg - 12'sd1;
            end
            OP_DIV_STEP: begin
                mx_reg <= sub_ok ? {mx_diff[23:0], 1'b0} : {mx_reg[23:0], 1'b0};
                q_reg  <= {q_reg[29:0] + {29'd0, sub_ok}, 1'b0};
                ex_reg <= ex_reg - 12'sd1;
            end
            OP_LAST_SUB: begin
                mx_reg <= sub_ok ? mx_diff : mx_reg;
                q_reg  <= q_reg + {30'd0, sub_ok};
                if ((sub_ok ? mx_diff : mx_reg) == 25'd0) begin
                    ex_reg <= ZERO_EXP_MARK;
                end
            end
            OP_PACK: begin
                rb_reg <= pack_rb;
            end
            OP_ADJ_SETUP: begin
                d_reg   <= d_new;
                es_reg  <= es_f;
                adj_reg <= 1'b1;
            end
            OP_ADJ_STEP: begin
                d_reg  <= {d_reg[22:0], 1'b0};
                es_reg <= es_reg - 8'd1;
            end
            OP_OUT_NAN: begin
                rem_reg <= CANON_NAN;
                quo_reg <= 32'd0;
            end
            OP_OUT_X: begin
                rem_reg <= xb_reg;
                quo_reg <= 32'd0;
            end
            OP_OUT_CALC: begin
                rem_reg <= final_rb ^ {xb_reg[31], 31'd0};
                quo_reg <= (xb_reg[31] ^ yb_reg[31]) ? (32'd0 - {1'b0, qf}) : {1'b0, qf};
            end
            default: begin
            end
        endcase
    end

    assign remainder_bits = rem_reg;
    assign quotient_low   = quo_reg;
endmodule
`default_nettype wire

>>> sv/frq_ctrl.sv
// Sequencer of the float32 remainder and quotient block and its output handshake.
`default_nettype none
`include "float32_remainder_quotient_macros.svh"
module frq_ctrl
    import frq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);
    typedef enum logic [3:0] {
        IDLE, CHECK, NORM_X, NORM_Y, CLASSIFY, DIVIDE, RENORM, PACK, DECIDE, ADJ_NORM, FINISH
    } state_t;

    state_t state_reg, state_next;
    dp_op_t kind_reg, kind_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_cmd;

    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd.op        = OP_NONE;
        case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = CHECK;
                end
            end
            CHECK: begin
                if (status.invalid) begin
                    kind_next  = OP_OUT_NAN;
                    state_next = FINISH;
                end else if (status.x_zero) begin
                    kind_next  = OP_OUT_X;
                    state_next = FINISH;
                end else begin
                    state_next = NORM_X;
                end
            end
            NORM_X: begin
                if (!status.mx_top) begin
                    cmd.op = OP_NORM_X;
                end else begin
                    state_next = NORM_Y;
                end
            end
            NORM_Y: begin
                if (!status.my_top) begin
                    cmd.op = OP_NORM_Y;
                end else begin
                    state_next = CLASSIFY;
                end
            end
            CLASSIFY: begin
                if (status.x_far) begin
                    kind_next  = OP_OUT_X;
                    state_next = FINISH;
                end else if (status.x_below) begin
                    state_next = PACK;
                end else begin
                    state_next = DIVIDE;
                end
            end
            DIVIDE: begin
                if (status.div_more) begin
                    cmd.op = OP_DIV_STEP;
                end else begin
                    cmd.op     = OP_LAST_SUB;
                    state_next = RENORM;
                end
            end
            RENORM: begin
                if (status.mx_zero || status.mx_top) begin
                    state_next = PACK;
                end else begin
                    cmd.op = OP_RENORM;
                end
            end
            PACK: begin
                cmd.op     = OP_PACK;
                state_next = DECIDE;
            end
            DECIDE: begin
                if (status.need_adj) begin
                    cmd.op     = OP_ADJ_SETUP;
                    state_next = ADJ_NORM;
                end else begin
                    kind_next  = OP_OUT_CALC;
                    state_next = FINISH;
                end
            end
            ADJ_NORM: begin
                if (status.adj_more) begin
                    cmd.op = OP_ADJ_STEP;
                end else begin
                    kind_next  = OP_OUT_CALC;
                    state_next = FINISH;
                end
            end
            FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = kind_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            kind_reg     <= OP_NONE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = state_reg == IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign out_cmd  = (cmd.op == OP_OUT_NAN) || (cmd.op == OP_OUT_X)
                      || (cmd.op == OP_OUT_CALC);

    `FRQ_ASSERT_IMPL(a_no_overwrite, m_tvalid_reg && !m_tready, !out_cmd)
    `FRQ_ASSERT_NEXT(a_out_valid, out_cmd, m_tvalid_reg)
    `FRQ_ASSERT_IMPL(a_norm_nonzero, state_reg == NORM_X, !status.x_zero && !status.invalid)
    `FRQ_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready)
endmodule
`default_nettype wire

>>> dv/frq_checker.sv
// Checker that predicts and compares every result beat of the remainder and quotient block.
`default_nettype none
module frq_checker
    import frq_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [63:0] m_tdata,
    output int               pending,
    output int               fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] quo;
    } remquo_t;

    remquo_t expected_q[$];

    initial fail_count = 0;
    initial pending = 0;

    function automatic logic [30:0] near_diff(logic [31:0] big, logic [31:0] sml);
        int eb;
        int es;
        int d;
        longint unsigned sb;
        longint unsigned ss;
        longint unsigned dd;
        eb = big[30:23];
        es = sml[30:23];
        sb = big[22:0];
        ss = sml[22:0];
        if (eb != 0) sb |= HIDDEN_BIT; else eb = 1;
        if (es != 0) ss |= HIDDEN_BIT; else es = 1;
        d = eb - es;
        if (d < 0) d = 0;
        if (d > 7) d = 7;
        dd = (sb << d) - ss;
        if (dd > 64'hff_ffff) dd &= 64'hff_ffff;
        while (dd != 0 && dd < HIDDEN_BIT && es > 1) begin
            dd <<= 1;
            es--;
        end
        if (dd == 0) return '0;
        return 31'((longint'(es - 1) << 23) + dd);
    endfunction

    function automatic remquo_t predict_remquo(logic [31:0] xb, logic [31:0] yb);
        remquo_t res;
        int ex;
        int ey;
        int sh;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] q;
        logic [31:0] rb;
        logic [31:0] twox;
        logic [31:0] yabs;
        bit zero;
        ex = xb[30:23];
        ey = yb[30:23];
        yabs = {1'b0, yb[30:0]};
        q = '0;
        zero = 0;
        if (yb[30:0] == 0 || yabs > INF_PATTERN || ex == 255) begin
            res.rem = CANON_NAN;
            res.quo = '0;
            return res;
        end
        if (xb[30:0] == 0) begin
            res.rem = xb;
            res.quo = '0;
            return res;
        end
        if (ex == 0) begin
            mx = {9'd0, xb[22:0]} << 1;
            while (mx[23] == 0) begin mx <<= 1; ex--; end
        end else begin
            mx = {9'd1, xb[22:0]};
        end
        if (ey == 0) begin
            my = {9'd0, yb[22:0]} << 1;
            while (my[23] == 0) begin my <<= 1; ey--; end
        end else begin
            my = {9'd1, yb[22:0]};
        end
        if (ex < ey) begin
            if (ex + 1 != ey) begin
                res.rem = xb;
                res.quo = '0;
                return res;
            end
        end else begin
            for (; ex > ey; ex--) begin
                if (mx >= my) begin mx -= my; q++; end
                mx <<= 1;
                q <<= 1;
            end
            if (mx >= my) begin mx -= my; q++; end
            if (mx == 0) begin
                zero = 1;
                ex = int'(ZERO_EXP_MARK);
            end else begin
                while (mx[23] == 0) begin mx <<= 1; ex--; end
            end
        end
        if (zero) begin
            rb = '0;
        end else if (ex > 0) begin
            rb = (mx - HIDDEN_BIT) | (32'(ex) << 23);
        end else begin
            sh = 1 - ex;
            rb = (sh < 32) ? (mx >> sh) : '0;
        end
        if ((rb >> 23) == 0) twox = rb << 1;
        else if ((rb >> 23) >= 254) twox = INF_PATTERN;
        else twox = rb + HIDDEN_BIT;
        if (ex == ey || (ex + 1 == ey && (twox > yabs || (twox == yabs && q[0])))) begin
            rb = {1'b1, near_diff(yabs, rb)};
            q++;
        end
        q[31] = 1'b0;
        res.rem = rb ^ {xb[31], 31'd0};
        res.quo = (xb[31] ^ yb[31]) ? (32'd0 - q) : q;
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t: mismatch on %s: got %08h, expected %08h", $realtime, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        remquo_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_q.push_back(predict_remquo(s_tdata[31:0], s_tdata[63:32]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result beat", m_tdata[31:0], 32'd0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_tdata[31:0] !== want.rem)
                        report_mismatch("remainder_bits", m_tdata[31:0], want.rem);
                    if (m_tdata[63:32] !== want.quo)
                        report_mismatch("quotient_low", m_tdata[63:32], want.quo);
                end
            end
        end
        pending = expected_q.size();
    end
endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench top for the float32 remainder and quotient block: stimulus, stalls and verdict.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1830;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          pending;
    int          fail_count;
    int          cycle = 0;
    bit          no_idle_tx = 0;

    always #1 aclk = ~aclk;

    float32_remainder_quotient dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    frq_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    always @(posedge aclk) cycle <= cycle + 1;

    // Receiver: random stalls, one long hold-off, and a long stretch always ready.
    always @(posedge aclk) begin
        if (cycle >= 3000 && cycle < 6000) m_tready <= 1'b0;
        else if (cycle >= 20000 && cycle < 32000) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(99) >= 28);
    end

    function automatic logic [31:0] make_float(logic s, int e, logic [22:0] f);
        return {s, 8'(e), f};
    endfunction

    task automatic send_beat(logic [31:0] x, logic [31:0] y);
        int gap;
        gap = 0;
        if (!no_idle_tx && $urandom_range(99) < 28) gap = $urandom_range(1, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_random_beat();
        logic [31:0] x;
        logic [31:0] y;
        int ey;
        ey = $urandom_range(1, 254);
        y = make_float($urandom_range(1), ey, 23'($urandom));
        x = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: x = make_float($urandom_range(1),
                            (ey + $urandom_range(0, 24) > 254) ? 254 : ey + $urandom_range(0, 24),
                            23'($urandom));
            4: x = make_float($urandom_range(1), ey - 1 > 0 ? ey - 1 : 0,
                              $urandom_range(1) ? 23'($urandom) : {1'b0, 22'd0});
            5: x = make_float($urandom_range(1), ey, $urandom_range(1) ? 23'd0 : y[22:0]);
            6: begin
                x = make_float($urandom_range(1), 0, 23'($urandom));
                if ($urandom_range(1)) y = make_float($urandom_range(1), 0, 23'($urandom));
            end
            7: begin
                case ($urandom_range(5))
                    0: y[30:0] = '0;
                    1: y[30:23] = 8'hff;
                    2: x[30:23] = 8'hff;
                    3: x[30:0] = '0;
                    4: y = make_float(y[31], 255, 23'd0);
                    default: x = make_float(x[31], 254, 23'($urandom));
                endcase
            end
            8: x = make_float($urandom_range(1), $urandom_range(ey, 254), {20'd0, 3'($urandom)});
            default: y = $urandom;
        endcase
        send_beat(x, y);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        m_tready <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_beat(32'h3f80_0000, 32'h0000_0000);
        send_beat(32'h3f80_0000, 32'h8000_0000);
        send_beat(32'h7f80_0000, 32'h3f80_0000);
        send_beat(32'hffc0_0001, 32'h3f80_0000);
        send_beat(32'h3f80_0000, 32'h7f80_0001);
        send_beat(32'hffff_ffff, 32'hffff_ffff);
        send_beat(32'h0000_0000, 32'h3f80_0000);
        send_beat(32'h8000_0000, 32'h4040_0000);
        send_beat(32'hbf80_0000, 32'hff80_0000);
        send_beat(32'h0000_0001, 32'h7f7f_ffff);
        send_beat(32'h4040_0000, 32'h4000_0000);
        send_beat(32'h40a0_0000, 32'h4000_0000);
        send_beat(32'h3f80_0000, 32'h4000_0000);
        send_beat(32'h3fc0_0000, 32'h4000_0000);
        send_beat(32'h40c0_0000, 32'h4040_0000);
        send_beat(32'hc0c0_0000, 32'h4040_0000);
        send_beat(32'hc0f0_0000, 32'hc000_0000);
        send_beat(32'h7f7f_ffff, 32'h0000_0001);
        send_beat(32'h7f7f_ffff, 32'h3f80_0000);
        send_beat(32'h0000_0001, 32'h0000_0001);
        send_beat(32'h807f_ffff, 32'h0000_0003);
        send_beat(32'h7f7f_ffff, 32'h8080_0000);
        for (int i = 0; i < RANDOM_BEATS; i++) begin
            if (i == 500) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
                wait (pending == 0);
                @(posedge aclk);
            end
            no_idle_tx = (i >= 900 && i < 1150);
            send_random_beat();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        repeat (400) @(posedge aclk);
        if (fail_count == 0) begin
            $display("float32_remainder_quotient test passed");
        end else begin
            $display("float32_remainder_quotient test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("float32_remainder_quotient test failed");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
+incdir+sv
sv/frq_pkg.sv
sv/frq_datapath.sv
sv/frq_ctrl.sv
sv/float32_remainder_quotient.sv
dv/frq_checker.sv
dv/tb_top.sv
